### rtl/sww_pkg.sv
// Package for the sine waveshaper: widths, fixed-point constants, the CORDIC
// angle table and the item types used by all modules of the block.
// No dependencies.
package sww_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int SINE_STAGES  = 16;

	localparam int N_STAGES = (SINE_STAGES > 32) ? 32 : SINE_STAGES;
	localparam int FRAC     = SAMPLE_WIDTH - 1;
	localparam int WRAP_W   = 16;
	localparam int GAIN_W   = WRAP_W + 15;
	localparam int PROD_W   = SAMPLE_WIDTH + GAIN_W + 1;
	localparam int PH_SH    = SAMPLE_WIDTH - 5;
	localparam int PH_W     = 32;
	localparam int CW       = 34;
	localparam int RW       = CW + 2;
	localparam int RND_SH   = (FRAC < 30) ? (30 - FRAC) : 1;

	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;
	localparam logic REG_WRAP = 1'b0;

	localparam logic [GAIN_W-1:0] GAIN_MIN  = GAIN_W'(2136141);
	localparam logic [CW-1:0]     CORDIC_X0 = CW'(652032874);

	localparam logic [31:0] ATAN_TURNS [32] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
		32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81,
		32'd41, 32'd20, 32'd10, 32'd5,
		32'd3, 32'd1, 32'd1, 32'd0
	};

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] in_sample;
		logic                           block_end;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] out_sample;
		logic                           out_block_end;
	} out_item_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic                 blk;
	} cordic_t;

endpackage

### rtl/sww_cordic.sv
// Pipelined CORDIC rotation, one register stage per iteration, with a valid
// bit per stage and per-stage ready so that bubbles are squeezed out.
// Depends on sww_pkg.
module sww_cordic
	import sww_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  cordic_t in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output cordic_t out_data
);

	logic    v_s  [N_STAGES];
	cordic_t st_s [N_STAGES];
	logic    en   [N_STAGES];

	genvar i;
	generate
		for (i = 0; i < N_STAGES; i++) begin : g_stage
			logic    prv_v;
			cordic_t prv;
			cordic_t nxt;
			logic signed [CW-1:0] ang;

			if (i == 0) begin : g_first
				assign prv_v = in_valid;
				assign prv   = in_data;
			end else begin : g_rest
				assign prv_v = v_s[i-1];
				assign prv   = st_s[i-1];
			end

			if (i == N_STAGES - 1) begin : g_last_en
				assign en[i] = !v_s[i] || out_ready;
			end else begin : g_mid_en
				assign en[i] = !v_s[i] || en[i+1];
			end

			assign ang = $signed({{(CW-32){1'b0}}, ATAN_TURNS[i]});

			always_comb begin
				nxt.blk = prv.blk;
				if (!prv.z[CW-1]) begin
					nxt.x = prv.x - (prv.y >>> i);
					nxt.y = prv.y + (prv.x >>> i);
					nxt.z = prv.z - ang;
				end else begin
					nxt.x = prv.x + (prv.y >>> i);
					nxt.y = prv.y - (prv.x >>> i);
					nxt.z = prv.z + ang;
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[i] <= 1'b0;
				end else if (en[i]) begin
					v_s[i] <= prv_v;
				end
			end

			always_ff @(posedge clk) begin
				if (en[i] && prv_v) begin
					st_s[i] <= nxt;
				end
			end
		end
	endgenerate

	assign in_ready  = en[0];
	assign out_valid = v_s[N_STAGES-1];
	assign out_data  = st_s[N_STAGES-1];

endmodule

### rtl/sine_wave_wrapper.sv
// Top level of the sine waveshaper: configuration port, gain, product,
// phase fold, CORDIC pipeline and output rounding. Depends on sww_pkg and sww_cordic.
//
// The block takes one item per clock cycle unless the output stalls, and
// returns one result per item, in order. Each item passes the gain select,
// multiply, phase fold, CORDIC iteration and rounding registers in turn.
// Each stage has its own valid bit and holds its item while the output is
// stalled, so empty stages keep filling. The user must write the wrap register
// through the APB port only while the block is idle; the block does not enforce it.
module sine_wave_wrapper
	import sww_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_data
);

	localparam logic signed [RW-1:0] SAT_HI = RW'((64'sd1 <<< FRAC) - 64'sd1);
	localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);

	logic [WRAP_W-1:0] wrap_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_WRAP);
	assign prdata = (paddr[2] == REG_WRAP) ? {{(DATA_W-WRAP_W){1'b0}}, wrap_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_q <= '0;
		end else if (wr_en) begin
			wrap_q <= pwdata[WRAP_W-1:0];
		end
	end

	logic                           v_s1, v_s2, v_s3, out_valid_q;
	logic                           en_s1, en_s2, en_s3, en_out;
	logic signed [SAMPLE_WIDTH-1:0] smp_s1;
	logic [GAIN_W-1:0]              gain_s1;
	logic                           blk_s1, blk_s2;
	logic signed [PROD_W-1:0]       prod_s2;
	cordic_t                        cin_s3;
	out_item_t                      out_q;

	logic [GAIN_W-1:0]        gain_raw, gain_c;
	logic signed [PROD_W-1:0] prod_c;
	logic [PH_W-1:0]          ph_c, fph_c;
	cordic_t                  cin_c;
	logic                     cin_ready, cout_valid;
	cordic_t                  cout;
	logic signed [RW-1:0]     yw_c, rnd_c;
	out_item_t                out_c;

	assign en_out   = !out_valid_q || out_ready;
	assign en_s3    = !v_s3 || cin_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	assign gain_raw = {wrap_q, 15'b0};
	assign gain_c   = (gain_raw < GAIN_MIN) ? GAIN_MIN : gain_raw;
	assign prod_c   = $signed(smp_s1) * $signed({1'b0, gain_s1});
	assign ph_c     = prod_s2[PH_SH+PH_W-1:PH_SH];

	always_comb begin
		if (ph_c[31:30] == 2'b01 || ph_c[31:30] == 2'b10) begin
			fph_c = 32'h8000_0000 - ph_c;
		end else begin
			fph_c = ph_c;
		end
		cin_c.x   = $signed(CORDIC_X0);
		cin_c.y   = '0;
		cin_c.z   = $signed({{(CW-PH_W){fph_c[PH_W-1]}}, fph_c});
		cin_c.blk = blk_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_out) begin
				out_valid_q <= cout_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			smp_s1  <= in_data.in_sample;
			blk_s1  <= in_data.block_end;
			gain_s1 <= gain_c;
		end
		if (en_s2 && v_s1) begin
			prod_s2 <= prod_c;
			blk_s2  <= blk_s1;
		end
		if (en_s3 && v_s2) begin
			cin_s3 <= cin_c;
		end
		if (en_out && cout_valid) begin
			out_q <= out_c;
		end
	end

	sww_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s3),
		.in_ready (cin_ready),
		.in_data  (cin_s3),
		.out_valid(cout_valid),
		.out_ready(en_out),
		.out_data (cout)
	);

	always_comb begin
		yw_c = $signed({{(RW-CW){cout.y[CW-1]}}, cout.y});
		if (FRAC < 30) begin
			rnd_c = (yw_c + (RW'(1) <<< (RND_SH - 1))) >>> RND_SH;
		end else if (FRAC == 30) begin
			rnd_c = yw_c;
		end else begin
			rnd_c = yw_c <<< 1;
		end
		if (rnd_c > SAT_HI) begin
			out_c.out_sample = SAT_HI[SAMPLE_WIDTH-1:0];
		end else if (rnd_c < SAT_LO) begin
			out_c.out_sample = SAT_LO[SAMPLE_WIDTH-1:0];
		end else begin
			out_c.out_sample = rnd_c[SAMPLE_WIDTH-1:0];
		end
		out_c.out_block_end = cout.blk;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ready || !out_valid) |-> in_ready)
		else $error("input stalled although the output side can drain");

	a_gain_floor: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (gain_s1 >= GAIN_MIN))
		else $error("gain below its floor");

	a_wrap_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (wrap_q == $past(pwdata[WRAP_W-1:0])))
		else $error("wrap register write lost");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !cin_ready) |=> (v_s3 && $stable(cin_s3)))
		else $error("fold stage changed while stalled");

endmodule
